/* hdl/bounded_double_ended_queue_macros.svh */
// Assertion helpers, sampled on clk and held off while rst_n is low.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BDQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bdq_pkg.sv */
package bdq_pkg;

  localparam int KEY_W        = 32;
  localparam int OCC_W        = 5;
  localparam int DEF_CAPACITY = 16;

  typedef enum logic [1:0] {
    CMD_PUSH_L = 2'd0,
    CMD_PUSH_R = 2'd1,
    CMD_POP_L  = 2'd2,
    CMD_POP_R  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef logic signed [KEY_W-1:0] key_t;

  // Per-cell controls for one step of the chain.
  typedef struct packed {
    logic shift_r;  // push at left: take the left neighbor
    logic shift_l;  // pop at left: take the right neighbor
    logic load;     // push at right lands in this cell
    logic tap;      // this cell is the rightmost stored key
  } cell_ctl_t;

endpackage

/* hdl/bdq_in_if.sv */
interface bdq_in_if
  import bdq_pkg::*;
();
  logic valid;
  logic ready;
  cmd_t command;
  key_t key_in;

  modport source (output valid, output command, output key_in, input ready);
  modport sink   (input valid, input command, input key_in, output ready);
endinterface

/* hdl/bdq_out_if.sv */
interface bdq_out_if
  import bdq_pkg::*;
();
  logic             valid;
  logic             ready;
  status_t          status;
  key_t             key_out;
  logic [OCC_W-1:0] occupancy;
  logic             is_full;
  logic             is_empty;

  modport source (output valid, output status, output key_out, output occupancy,
                  output is_full, output is_empty, input ready);
  modport sink   (input valid, input status, input key_out, input occupancy,
                  input is_full, input is_empty, output ready);
endinterface

/* hdl/bounded_double_ended_queue.sv */
// Bounded deque of 32-bit keys, CAPACITY entries deep.
// in_ch (sink): valid/ready with command and key_in; a transfer happens when
//   both are high. Commands: push left, push right, pop left, pop right.
// out_ch (source): one result per command: status, popped key (zero unless
//   a pop succeeded), occupancy after the step, full and empty flags.
// Keys sit in a row of cells, leftmost key in cell 0. A left push shifts the
// row right, a left pop shifts it left, a right push loads the cell at the
// count, and a right pop reads the cell just below the count.
// The result is registered and valid in the cycle after the command transfer.
// Throughput: one command per cycle while out_ch takes each result; the whole row
//   updates together and a right pop is one AND-OR select across the cells.
// Reset empties the queue (count zero); cell contents are not cleared.
// When out_ch stalls, the result register holds and in_ch.ready drops until
//   the result is taken; ready is high again in the cycle it is taken.
module bounded_double_ended_queue
  import bdq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic         clk,
  input  logic         rst_n,
  bdq_in_if.sink       in_ch,
  bdq_out_if.source    out_ch
);

`include "bounded_double_ended_queue_macros.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  status_t          status_r, status_nxt;
  key_t             key_out_r, key_out_nxt;
  logic [OCC_W-1:0] occ_r;
  logic             full_r, empty_r;

  logic xfer, full, empty, is_push, refused;
  logic push_l, push_r, pop_l, pop_r;

  cell_ctl_t ctl     [CAPACITY];
  key_t      cell_q  [CAPACITY];
  key_t      tap_q   [CAPACITY];
  key_t      right_key;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign xfer        = in_ch.valid && in_ch.ready;

  assign full    = (count_r == CAP_CNT);
  assign empty   = (count_r == '0);
  assign is_push = (in_ch.command == CMD_PUSH_L) || (in_ch.command == CMD_PUSH_R);
  assign refused = is_push ? full : empty;

  assign push_l = xfer && !refused && (in_ch.command == CMD_PUSH_L);
  assign push_r = xfer && !refused && (in_ch.command == CMD_PUSH_R);
  assign pop_l  = xfer && !refused && (in_ch.command == CMD_POP_L);
  assign pop_r  = xfer && !refused && (in_ch.command == CMD_POP_R);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t from_left, from_right;

    if (i == 0) begin : g_left_end
      assign from_left = in_ch.key_in;
    end else begin : g_left_mid
      assign from_left = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_right_end
      assign from_right = '0;
    end else begin : g_right_mid
      assign from_right = cell_q[i+1];
    end

    assign ctl[i].shift_r = push_l;
    assign ctl[i].shift_l = pop_l;
    assign ctl[i].load    = push_r && (count_r == CNT_W'(i));
    assign ctl[i].tap     = (count_r == CNT_W'(i + 1));

    bdq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .key        (in_ch.key_in),
      .from_left  (from_left),
      .from_right (from_right),
      .q          (cell_q[i]),
      .tap_q      (tap_q[i])
    );
  end

  // At most one tap is live, so OR-ing the masked outputs selects it.
  always_comb begin
    right_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      right_key = right_key | tap_q[i];
    end
  end

  always_comb begin
    count_nxt   = count_r;
    status_nxt  = ST_DONE;
    key_out_nxt = '0;
    if (push_l || push_r) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_l) begin
      count_nxt   = count_r - CNT_W'(1);
      key_out_nxt = cell_q[0];
    end else if (pop_r) begin
      count_nxt   = count_r - CNT_W'(1);
      key_out_nxt = right_key;
    end else if (refused) begin
      status_nxt = is_push ? ST_FULL : ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (xfer) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      status_r  <= status_nxt;
      key_out_r <= key_out_nxt;
      occ_r     <= OCC_W'(count_nxt);
      full_r    <= (count_nxt == CAP_CNT);
      empty_r   <= (count_nxt == '0);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.key_out   = key_out_r;
  assign out_ch.occupancy = occ_r;
  assign out_ch.is_full   = full_r;
  assign out_ch.is_empty  = empty_r;

  `BDQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CAP_CNT, "count above capacity")
  `BDQ_ASSERT_NEXT(a_push_count, push_l || push_r, count_r == $past(count_r) + CNT_W'(1), "push did not grow count")
  `BDQ_ASSERT_NEXT(a_refused_stable, xfer && refused, $stable(count_r), "refused command changed count")
  `BDQ_ASSERT_NEXT(a_result_follows, xfer, out_valid_r, "no result after command transfer")
  `BDQ_ASSERT_NOW(a_key_zero, out_valid_r && (status_r != ST_DONE), key_out_r == '0, "refused result with nonzero key")

endmodule

/* hdl/bdq_cell.sv */
module bdq_cell
  import bdq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  key_t      key,
  input  key_t      from_left,
  input  key_t      from_right,
  output key_t      q,
  output key_t      tap_q
);

  key_t data_r;

  always_ff @(posedge clk) begin
    if (ctl.shift_r) begin
      data_r <= from_left;
    end else if (ctl.shift_l) begin
      data_r <= from_right;
    end else if (ctl.load) begin
      data_r <= key;
    end
  end

  assign q     = data_r;
  assign tap_q = ctl.tap ? data_r : '0;

endmodule

/* sim/bounded_double_ended_queue_tb.sv */
module bounded_double_ended_queue_tb
  import bdq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = DEF_CAPACITY;
  localparam int RANDOM_ITEMS   = 450;
  localparam int TAIL_ITEMS     = 60;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    status_t          status;
    key_t             key;
    logic [OCC_W-1:0] occupancy;
    logic             full;
    logic             empty;
  } deque_result_t;

  typedef struct packed {
    cmd_t          cmd;
    key_t          key;
    int            reps;
    logic          typed;
    deque_result_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  bdq_in_if  cmd_ch ();
  bdq_out_if res_ch ();

  bounded_double_ended_queue #(
    .CAPACITY(DEPTH)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (cmd_ch),
    .out_ch(res_ch)
  );

  // Shadow deque: ring with a left pointer and a one-past-right pointer.
  key_t ring_keys [DEPTH];
  int   left_ptr;
  int   right_ptr;
  int   key_count;

  deque_result_t pending_results [$];
  int            error_count;
  int            stall_cycles;
  bit            quiet_tail;
  bit            sender_gaps;

  // Directed rows; typed rows carry their result, the rest use the shadow deque.
  stim_row_t directed_rows [13] = '{
    '{CMD_POP_L,  32'sh0000_0000,  1, 1'b1, '{ST_EMPTY, 32'sh0, 5'd0, 1'b0, 1'b1}},
    '{CMD_POP_R,  32'sh1234_5678,  1, 1'b1, '{ST_EMPTY, 32'sh0, 5'd0, 1'b0, 1'b1}},
    '{CMD_PUSH_R, 32'sh7FFF_FFFF,  1, 1'b1, '{ST_DONE, 32'sh0, 5'd1, 1'b0, 1'b0}},
    '{CMD_PUSH_L, 32'sh8000_0000,  1, 1'b1, '{ST_DONE, 32'sh0, 5'd2, 1'b0, 1'b0}},
    '{CMD_POP_L,  32'sh0000_0000,  1, 1'b1, '{ST_DONE, 32'sh8000_0000, 5'd1, 1'b0, 1'b0}},
    '{CMD_POP_R,  32'shFFFF_FFFF,  1, 1'b1, '{ST_DONE, 32'sh7FFF_FFFF, 5'd0, 1'b0, 1'b1}},
    // left push from slot zero wraps the left pointer
    '{CMD_PUSH_L, 32'shFFFF_FFFF,  1, 1'b0, '0},
    '{CMD_PUSH_R, 32'sh0000_0100, 14, 1'b0, '0},
    '{CMD_PUSH_L, 32'sh0000_0000,  1, 1'b0, '0},
    '{CMD_PUSH_R, 32'shDEAD_BEEF,  1, 1'b1, '{ST_FULL, 32'sh0, 5'd16, 1'b1, 1'b0}},
    '{CMD_PUSH_L, 32'sh7FFF_FFFF,  1, 1'b1, '{ST_FULL, 32'sh0, 5'd16, 1'b1, 1'b0}},
    '{CMD_POP_L,  32'sh0000_0000,  1, 1'b0, '0},
    '{CMD_POP_R,  32'sh0000_0000,  1, 1'b0, '0}
  };

  function automatic deque_result_t apply_command(cmd_t cmd, key_t key);
    deque_result_t res;
    res.status = ST_DONE;
    res.key    = '0;
    case (cmd)
      CMD_PUSH_L, CMD_PUSH_R: begin
        if (key_count >= DEPTH) begin
          res.status = ST_FULL;
        end else if (cmd == CMD_PUSH_L) begin
          left_ptr = (left_ptr + DEPTH - 1) % DEPTH;
          ring_keys[left_ptr] = key;
          key_count++;
        end else begin
          ring_keys[right_ptr] = key;
          right_ptr = (right_ptr + 1) % DEPTH;
          key_count++;
        end
      end
      default: begin
        if (key_count == 0) begin
          res.status = ST_EMPTY;
        end else if (cmd == CMD_POP_L) begin
          res.key  = ring_keys[left_ptr];
          left_ptr = (left_ptr + 1) % DEPTH;
          key_count--;
        end else begin
          right_ptr = (right_ptr + DEPTH - 1) % DEPTH;
          res.key   = ring_keys[right_ptr];
          key_count--;
        end
      end
    endcase
    res.occupancy = OCC_W'(key_count);
    res.full      = (key_count == DEPTH);
    res.empty     = (key_count == 0);
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Drive one command, wait for its transfer, then record what it should return.
  task automatic issue(cmd_t cmd, key_t key, logic typed, deque_result_t want);
    deque_result_t predicted;
    if (sender_gaps && !quiet_tail && $urandom_range(0, 4) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.command <= cmd;
    cmd_ch.key_in  <= key;
    do @(posedge clk); while (!cmd_ch.ready);
    predicted = apply_command(cmd, key);
    pending_results.push_back(typed ? want : predicted);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: random ready stalls, calm stretches, none in the tail.
  initial begin : result_side
    int n;
    forever begin
      n = $urandom_range(0, 7);
      if (!quiet_tail && n <= 1) begin
        repeat ($urandom_range(1, 16)) begin
          res_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end else if (n == 2) begin
        repeat ($urandom_range(20, 60)) begin
          res_ch.ready <= 1'b1;
          @(posedge clk);
        end
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    deque_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending: expected none actual %0h",
                 $time, res_ch.key_out);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status",    32'(want.status),    32'(res_ch.status));
        check_field("key_out",   want.key,            res_ch.key_out);
        check_field("occupancy", 32'(want.occupancy), 32'(res_ch.occupancy));
        check_field("is_full",   32'(want.full),      32'(res_ch.is_full));
        check_field("is_empty",  32'(want.empty),     32'(res_ch.is_empty));
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("FAIL bounded_double_ended_queue");
    $finish;
  end

  initial begin : stimulus
    int   seg_left;
    int   push_weight;
    logic is_push;
    logic right_side;
    cmd_t cmd;
    key_t key;

    error_count    = 0;
    stall_cycles   = 0;
    quiet_tail     = 1'b0;
    sender_gaps    = 1'b1;
    left_ptr       = 0;
    right_ptr      = 0;
    key_count      = 0;
    seg_left       = 0;
    push_weight    = 50;
    rst_n          <= 1'b0;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.command <= CMD_PUSH_L;
    cmd_ch.key_in  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++)
        issue(directed_rows[r].cmd, key_t'(directed_rows[r].key + k),
              directed_rows[r].typed, directed_rows[r].want);
    end

    // Segments lean toward pushes, toward pops or neither, so the queue keeps hitting full and empty.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 40);
        case ($urandom_range(0, 2))
          0:       push_weight = 20;
          1:       push_weight = 50;
          default: push_weight = 85;
        endcase
        sender_gaps = ($urandom_range(0, 3) != 0);
      end
      seg_left--;
      quiet_tail = (i >= RANDOM_ITEMS - TAIL_ITEMS);

      if (i % 150 == 75) begin
        // hold off until the block has returned everything
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end

      is_push    = ($urandom_range(0, 99) < push_weight);
      right_side = 1'($urandom_range(0, 1));
      cmd = is_push ? (right_side ? CMD_PUSH_R : CMD_PUSH_L)
                    : (right_side ? CMD_POP_R : CMD_POP_L);
      case ($urandom_range(0, 11))
        0:       key = 32'sh0000_0000;
        1:       key = 32'shFFFF_FFFF;
        2:       key = 32'sh8000_0000;
        3:       key = 32'sh7FFF_FFFF;
        default: key = key_t'($urandom);
      endcase
      issue(cmd, key, 1'b0, '0);
    end

    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (8) @(posedge clk);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASS bounded_double_ended_queue");
    end else begin
      $display("FAIL bounded_double_ended_queue");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/bdq_pkg.sv
hdl/bdq_in_if.sv
hdl/bdq_out_if.sv
hdl/bdq_cell.sv
hdl/bounded_double_ended_queue.sv
sim/bounded_double_ended_queue_tb.sv
